// ===== sv/indexed_ordered_list_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/iol_pkg.sv =====
package iol_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int ENTRY_W  = 9;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [DATA_W-1:0] NO_VALUE = '1;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_PUSH_TAIL = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_HEAD   = 2'd1,
    CMD_TAIL   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  tail;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ===== sv/iol_cell.sv =====
module iol_cell (
  input  logic                        clk,
  input  iol_pkg::cmd_t               cmd,
  input  logic [iol_pkg::IDX_W-1:0]   idx,
  input  logic [iol_pkg::DATA_W-1:0]  prev_data,
  input  logic [iol_pkg::DATA_W-1:0]  next_data,
  output logic [iol_pkg::DATA_W-1:0]  data
);

  logic [iol_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      iol_pkg::CMD_HEAD: begin
        data_next = (idx == '0) ? cmd.value : prev_data;
      end
      iol_pkg::CMD_TAIL: begin
        if (idx == cmd.tail) begin
          data_next = cmd.value;
        end
      end
      iol_pkg::CMD_REMOVE: begin
        if (idx >= cmd.pos) begin
          data_next = next_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== sv/indexed_ordered_list.sv =====
// Ordered list of signed 32-bit entries held in a row of cells, position 0
// first. The input channel (in_valid, in_ready) carries one operation per
// beat: read at a position, insert at the head, insert at the tail, or
// remove at a position. The output channel (out_valid, out_ready) returns
// one result beat per operation with the value read, a status and the entry
// count after the operation.
// Every cell shifts, loads or holds in parallel, and a read is a position
// mux over the cells. The result is registered and appears in the cycle
// after the input beat. Throughput is one beat per cycle while the
// receiver keeps out_ready high. When the receiver stalls, the pending
// result holds and in_ready drops until it is taken; a new beat is
// accepted in the same cycle the old result leaves.
// Reset clears the entry count and the result valid flag; entry contents
// and result fields are not cleared, since only positions below the count
// are ever read and a result is only seen while out_valid is high.
`include "indexed_ordered_list_macros.svh"

module indexed_ordered_list (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [8:0]         entry_count
);

  localparam int CAP  = iol_pkg::CAPACITY;
  localparam int IW   = iol_pkg::IDX_W;
  localparam int CW   = iol_pkg::CNT_W;
  localparam int EW   = iol_pkg::ENTRY_W;
  localparam int DW   = iol_pkg::DATA_W;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           in_fire;
  logic           in_range;
  logic           full;
  iol_pkg::cmd_t  cmd;
  logic [DW-1:0]  cell_data [CAP];
  logic [DW-1:0]  rd_next;
  logic [1:0]     st_next;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign in_range = EW'(position) < EW'(count);
  assign full     = count == CW'(CAP);

  always_comb begin
    cmd.op    = iol_pkg::CMD_HOLD;
    cmd.pos   = IW'(position);
    cmd.tail  = IW'(count);
    cmd.value = item_value;
    rd_next    = iol_pkg::NO_VALUE;
    st_next    = iol_pkg::ST_OK;
    count_next = count;
    case (iol_pkg::op_t'(operation))
      iol_pkg::OP_READ: begin
        if (in_range) begin
          rd_next = cell_data[IW'(position)];
        end else begin
          st_next = iol_pkg::ST_RANGE;
        end
      end
      iol_pkg::OP_PUSH_HEAD, iol_pkg::OP_PUSH_TAIL: begin
        if (full) begin
          st_next = iol_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
          cmd.op = (iol_pkg::op_t'(operation) == iol_pkg::OP_PUSH_HEAD) ?
                   iol_pkg::CMD_HEAD : iol_pkg::CMD_TAIL;
        end
      end
      iol_pkg::OP_REMOVE: begin
        if (in_range) begin
          count_next = count - CW'(1);
          cmd.op = iol_pkg::CMD_REMOVE;
        end else begin
          st_next = iol_pkg::ST_RANGE;
        end
      end
      default: begin
        st_next = iol_pkg::ST_OK;
      end
    endcase
    if (!in_fire) begin
      cmd.op     = iol_pkg::CMD_HOLD;
      count_next = count;
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [DW-1:0] prev_d;
    logic [DW-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_next
      assign next_d = cell_data[i+1];
    end
    iol_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (IW'(i)),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_value  <= rd_next;
      status      <= st_next;
      entry_count <= EW'(count_next);
    end
  end

  `IOL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAP),
    "entry count exceeds capacity")

  `IOL_ASSERT_NEXT(a_fire_gives_result, clk, rst, in_fire, out_valid,
    "accepted beat produced no result")

  `IOL_ASSERT_NEXT(a_full_refused, clk, rst,
    in_fire && full && (operation == iol_pkg::OP_PUSH_HEAD ||
    operation == iol_pkg::OP_PUSH_TAIL),
    count == $past(count) && status == iol_pkg::ST_FULL,
    "insert into full list changed the count")

  `IOL_ASSERT_NEXT(a_remove_shrinks, clk, rst,
    in_fire && in_range && operation == iol_pkg::OP_REMOVE,
    count == $past(count) - CW'(1),
    "remove did not shrink the list by one")

endmodule
